// ===== sv/b64le_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_pkg: shared types, constants and a function
// Character codes, request codes, the queue entry type and the base64
// digit table used by the line-wrapped encoder.
// ----------------------------------------------------------------------------
package b64le_pkg;

  // Request codes on the input channel.
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_EOS  = 1'b1;

  // Special output characters.
  localparam logic [7:0] NL_CHAR  = 8'h0A;
  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Reset value of the groups-per-line register (76 characters).
  localparam logic [7:0] GPL_RESET = 8'd19;

  // Group phase codes: bytes of the current group already taken.
  localparam logic [1:0] PH_0      = 2'd0;
  localparam logic [1:0] PH_1      = 2'd1;
  localparam logic [1:0] PH_2      = 2'd2;
  localparam logic [1:0] PH_UNUSED = 2'd3;

  // One queue entry: up to three characters and the index of the last one.
  typedef struct packed {
    logic [7:0] ch0;
    logic [7:0] ch1;
    logic [7:0] ch2;
    logic [1:0] last_idx;
  } entry_t;

  // Maps a six-bit value to its base64 alphabet character.
  function automatic logic [7:0] digit_char(input logic [5:0] v);
    logic [7:0] v8;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      digit_char = 8'h41 + v8;
    end else if (v < 6'd52) begin
      digit_char = 8'h61 + (v8 - 8'd26);
    end else if (v < 6'd62) begin
      digit_char = 8'h30 + (v8 - 8'd52);
    end else if (v == 6'd62) begin
      digit_char = 8'h2B;
    end else begin
      digit_char = 8'h2F;
    end
  endfunction

endpackage

// ===== sv/b64le_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_front: request classifier
// Holds the group phase, carry bits and line count, turns each accepted
// request into at most one queue entry of one to three characters.
// ----------------------------------------------------------------------------
module b64le_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [7:0]          cfg_groups_per_line,
  input  logic                accept,
  input  logic                req_type,
  input  logic [7:0]          data_byte,
  output logic                push,
  output b64le_pkg::entry_t   push_entry
);

  logic [7:0] gpl_r;
  logic [1:0] phase_r, phase_nxt;
  logic [5:0] carry_r, carry_nxt;
  logic [7:0] line_r,  line_nxt;
  logic [1:0] ph;
  logic       has_chars;

  // Configuration register, written whenever a write request arrives.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gpl_r <= b64le_pkg::GPL_RESET;
    end else if (cfg_valid) begin
      gpl_r <= cfg_groups_per_line;
    end
  end

  // The unused phase code behaves like the start of a group.
  assign ph = (phase_r == b64le_pkg::PH_UNUSED) ? b64le_pkg::PH_0 : phase_r;

  // Classify the request and build its characters.
  always_comb begin
    phase_nxt  = phase_r;
    carry_nxt  = carry_r;
    line_nxt   = line_r;
    has_chars  = 1'b1;
    push_entry = '0;
    if (req_type == b64le_pkg::REQ_DATA) begin
      unique case (ph)
        b64le_pkg::PH_1: begin
          push_entry.ch0      = b64le_pkg::digit_char(carry_r | {2'b00, data_byte[7:4]});
          push_entry.last_idx = 2'd0;
          carry_nxt           = {data_byte[3:0], 2'b00};
          phase_nxt           = b64le_pkg::PH_2;
        end
        b64le_pkg::PH_2: begin
          push_entry.ch0      = b64le_pkg::digit_char(carry_r | {4'b0000, data_byte[7:6]});
          push_entry.ch1      = b64le_pkg::digit_char(data_byte[5:0]);
          push_entry.last_idx = 2'd1;
          carry_nxt           = '0;
          phase_nxt           = b64le_pkg::PH_0;
          line_nxt            = line_r + 8'd1;
        end
        default: begin
          if (line_r >= gpl_r) begin
            push_entry.ch0      = b64le_pkg::NL_CHAR;
            push_entry.ch1      = b64le_pkg::digit_char(data_byte[7:2]);
            push_entry.last_idx = 2'd1;
            line_nxt            = '0;
          end else begin
            push_entry.ch0      = b64le_pkg::digit_char(data_byte[7:2]);
            push_entry.last_idx = 2'd0;
          end
          carry_nxt = {data_byte[1:0], 4'b0000};
          phase_nxt = b64le_pkg::PH_1;
        end
      endcase
    end else begin
      // End of stream: flush, pad and return to the start of a line.
      push_entry.ch0 = b64le_pkg::digit_char(carry_r);
      push_entry.ch1 = b64le_pkg::PAD_CHAR;
      push_entry.ch2 = b64le_pkg::PAD_CHAR;
      unique case (ph)
        b64le_pkg::PH_1: push_entry.last_idx = 2'd2;
        b64le_pkg::PH_2: push_entry.last_idx = 2'd1;
        default: begin
          push_entry.last_idx = 2'd0;
          has_chars           = 1'b0;
        end
      endcase
      phase_nxt = b64le_pkg::PH_0;
      carry_nxt = '0;
      line_nxt  = '0;
    end
  end

  assign push = accept && has_chars;

  // Encoder state advances on every accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= b64le_pkg::PH_0;
      carry_r <= '0;
      line_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      carry_r <= carry_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

// ===== sv/b64le_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_queue: entry queue
// A short first-in first-out queue of character entries between the
// classifier and the serializer.
// ----------------------------------------------------------------------------
module b64le_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  b64le_pkg::entry_t  push_entry,
  output logic               not_full,
  input  logic               pop,
  output logic               not_empty,
  output b64le_pkg::entry_t  head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  b64le_pkg::entry_t    slot_r [DEPTH];
  logic [PW-1:0]        wptr_r, rptr_r;
  logic [CW-1:0]        cnt_r;
  logic                 do_push, do_pop;

  assign not_full  = (cnt_r != FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = slot_r[rptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == LAST_PTR) ? '0 : wptr_r + PW'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == LAST_PTR) ? '0 : rptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

// ===== sv/b64le_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_back: character serializer
// Takes queue entries and sends their characters one per cycle while
// out_ready is high, marking the final character of each entry.
// ----------------------------------------------------------------------------
module b64le_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  b64le_pkg::entry_t  q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_char,
  output logic               out_last
);

  b64le_pkg::entry_t cur_r;
  logic              busy_r;
  logic [1:0]        idx_r;
  logic              sent, done, load;

  assign out_valid = busy_r;
  assign out_last  = (idx_r == cur_r.last_idx);
  assign sent      = busy_r && out_ready;
  assign done      = sent && out_last;
  assign load      = !busy_r || done;
  assign q_pop     = load && q_not_empty;

  // Select the current character of the entry.
  always_comb begin
    case (idx_r)
      2'd0:    out_char = cur_r.ch0;
      2'd1:    out_char = cur_r.ch1;
      default: out_char = cur_r.ch2;
    endcase
  end

  // Entry register, taken without a gap after the last character.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

  // Busy flag and character index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (done) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (sent) begin
      idx_r <= idx_r + 2'd1;
    end
  end

endmodule

// ===== sv/base64_line_wrapped_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder: streaming line-wrapped base64 encoder
// Encodes a byte stream to base64 characters, inserts a newline after a
// configurable number of groups and pads the final group at end of stream.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Request contents
//   in_*      input      in_valid/in_ready    req_type, data_byte
//   out_*     output     out_valid/out_ready  out_char, out_last
//   cfg_*     input      cfg_valid/cfg_ready  groups_per_line
//
// An accepted request is registered into the queue; the serializer loads it
// once the entries ahead of it have been sent, and its characters then follow
// one per cycle while out_ready is high. The serializer's single output port
// sets the rate: four characters per three bytes, one more per newline,
// and up to three characters at flush.
// The queue of QUEUE_DEPTH entries lets input keep flowing while output
// stalls; in_ready drops only when the queue is full.
// Synchronous active-low reset; cfg_ready is always high.
//
module base64_line_wrapped_encoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_groups_per_line
);

  logic              accept;
  logic              push, q_not_full, q_not_empty, q_pop;
  b64le_pkg::entry_t push_entry, q_head;

  assign cfg_ready = 1'b1;
  assign in_ready  = q_not_full;
  assign accept    = in_valid && in_ready;

  // Classifier.
  b64le_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_groups_per_line (cfg_groups_per_line),
    .accept              (accept),
    .req_type            (in_req_type),
    .data_byte           (in_data_byte),
    .push                (push),
    .push_entry          (push_entry)
  );

  // Entry queue.
  b64le_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .not_full   (q_not_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // Serializer.
  b64le_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .out_last    (out_last)
  );

endmodule

// ===== sv/b64le_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64le_checker: port-level checks
// Watches the encoder's output channel for handshake and framing rules.
// ----------------------------------------------------------------------------
module b64le_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  // A stalled result request keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("output changed while stalled");

  // A newline is always followed by a digit of the same request.
  a_nl_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char == b64le_pkg::NL_CHAR |-> !out_last)
    else $error("newline marked last");

  // The digit after a newline follows in the next cycle.
  a_nl_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_char == b64le_pkg::NL_CHAR |=> out_valid)
    else $error("gap after newline");

  // A first pad character is followed at once by the final pad.
  a_pad_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_char == b64le_pkg::PAD_CHAR && !out_last
    |=> out_valid && out_char == b64le_pkg::PAD_CHAR && out_last)
    else $error("broken double pad");

endmodule

bind base64_line_wrapped_encoder b64le_checker u_b64le_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_char  (out_char),
  .out_last  (out_last)
);
